// File: rtl/core/tdcc_pkg.sv
// Shared types and constants for the tick-driven calendar clock.
package tdcc_pkg;

  localparam logic [15:0] TPS_RESET = 16'd5965;
  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Month length by month code; codes with no month count as 31 days.
  localparam logic [4:0] MONTH_DAYS [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic        func;
    logic [5:0]  load_seconds;
    logic [5:0]  load_minutes;
    logic [4:0]  load_hours;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
  } tdcc_req_t;

  typedef struct packed {
    logic [5:0]  out_seconds;
    logic [5:0]  out_minutes;
    logic [4:0]  out_hours;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic        second_elapsed;
  } tdcc_rsp_t;

endpackage

// File: rtl/core/tick_driven_calendar_clock.sv
// Tick-driven calendar clock: prescaler, calendar counters and result register.
//
// Request channel (req_valid / req_stall / req): each request is a timer
// tick (func = FUNC_TICK) or a load of all date and time fields
// (func = FUNC_LOAD). Every request yields exactly one response on
// rsp_valid / rsp_stall / rsp: the date and time after that request and a
// flag set when the tick completed a second.
// The response is registered: it appears in the cycle after the request
// is taken. Throughput is one request per cycle while req_stall is low;
// the limit is the single pass through the prescaler compare and the
// calendar carry chain between the state registers and the response register.
// req_stall is high only while a response sits in the output register and
// the receiver stalls it; taking that response frees the slot in the same
// cycle, so a new request can enter then.
// tps_we / tps_wdata set the ticks per second; write only while idle.
// Synchronous reset: prescaler 0, time 00:00:00, date day 1 month 1
// year 0, ticks per second 5965, no response pending.
module tick_driven_calendar_clock
  import tdcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  tdcc_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output tdcc_rsp_t rsp,
  input  logic      tps_we,
  input  logic [15:0] tps_wdata
);

  logic [15:0] ticks_per_second;
  logic [15:0] prescale_count;
  logic [5:0]  seconds_count;
  logic [5:0]  minutes_count;
  logic [4:0]  hours_count;
  logic [4:0]  day_count;
  logic [3:0]  month_count;
  logic [13:0] year_count;

  logic [15:0] prescale_count_next;
  logic [5:0]  seconds_count_next;
  logic [5:0]  minutes_count_next;
  logic [4:0]  hours_count_next;
  logic [4:0]  day_count_next;
  logic [3:0]  month_count_next;
  logic [13:0] year_count_next;
  logic        elapsed;
  logic [16:0] prescale_inc;
  logic        accept;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign prescale_inc = {1'b0, prescale_count} + 17'd1;

  always_comb begin
    prescale_count_next = prescale_count;
    seconds_count_next  = seconds_count;
    minutes_count_next  = minutes_count;
    hours_count_next    = hours_count;
    day_count_next      = day_count;
    month_count_next    = month_count;
    year_count_next     = year_count;
    elapsed             = 1'b0;
    if (req.func == FUNC_LOAD) begin
      prescale_count_next = '0;
      seconds_count_next  = req.load_seconds;
      minutes_count_next  = req.load_minutes;
      hours_count_next    = req.load_hours;
      day_count_next      = req.load_day;
      month_count_next    = req.load_month;
      year_count_next     = req.load_year;
    end else if (prescale_inc >= {1'b0, ticks_per_second}) begin
      prescale_count_next = '0;
      elapsed             = 1'b1;
      // carry chain: each field rolls only when all lower fields rolled
      if (seconds_count < SEC_MAX) begin
        seconds_count_next = seconds_count + 6'd1;
      end else begin
        seconds_count_next = '0;
        if (minutes_count < MIN_MAX) begin
          minutes_count_next = minutes_count + 6'd1;
        end else begin
          minutes_count_next = '0;
          if (hours_count < HOUR_MAX) begin
            hours_count_next = hours_count + 5'd1;
          end else begin
            hours_count_next = '0;
            if (day_count < MONTH_DAYS[month_count]) begin
              day_count_next = day_count + 5'd1;
            end else begin
              day_count_next = 5'd1;
              if (month_count < MONTH_MAX) begin
                month_count_next = month_count + 4'd1;
              end else begin
                month_count_next = 4'd1;
                if (year_count < YEAR_MAX) begin
                  year_count_next = year_count + 14'd1;
                end else begin
                  year_count_next = '0;
                end
              end
            end
          end
        end
      end
    end else begin
      prescale_count_next = prescale_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (tps_we) begin
      ticks_per_second <= tps_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      seconds_count  <= '0;
      minutes_count  <= '0;
      hours_count    <= '0;
      day_count      <= 5'd1;
      month_count    <= 4'd1;
      year_count     <= '0;
    end else if (accept) begin
      prescale_count <= prescale_count_next;
      seconds_count  <= seconds_count_next;
      minutes_count  <= minutes_count_next;
      hours_count    <= hours_count_next;
      day_count      <= day_count_next;
      month_count    <= month_count_next;
      year_count     <= year_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_seconds    <= seconds_count_next;
      rsp.out_minutes    <= minutes_count_next;
      rsp.out_hours      <= hours_count_next;
      rsp.out_day        <= day_count_next;
      rsp.out_month      <= month_count_next;
      rsp.out_year       <= year_count_next;
      rsp.second_elapsed <= elapsed;
    end
  end

`ifndef SYNTHESIS
  a_load_no_elapsed: assert property (@(posedge clk) disable iff (rst)
    accept && req.func == FUNC_LOAD |=> !rsp.second_elapsed && prescale_count == '0)
    else $error("load request flagged a second or left the prescaler running");

  a_accept_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request produced no response");

  a_elapsed_clears_prescale: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.second_elapsed |-> prescale_count == '0)
    else $error("second elapsed but prescaler not cleared");

  a_time_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !rst && !accept |=> $stable(seconds_count) && $stable(prescale_count)
                        && $stable(day_count))
    else $error("calendar state changed without a request");

  a_rsp_matches_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.out_seconds == seconds_count && rsp.out_year == year_count)
    else $error("response out of step with calendar state");
`endif

endmodule
